### src/trapezoid_polynomial_integrator_top_macros.svh
// Assertion macros for the trapezoid integrator.
// Used by the top level only; depends on nothing.
`ifndef TRAPEZOID_POLYNOMIAL_INTEGRATOR_TOP_MACROS_SVH
`define TRAPEZOID_POLYNOMIAL_INTEGRATOR_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define TPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpi check failed");
// next-cycle implication
`define TPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpi check failed");
`endif

### src/tpi_pkg.sv
// Shared types and constants for the trapezoid integrator.
// No dependencies.
package tpi_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ENDS, ST_ENDB, ST_LOOP, ST_DRAIN, ST_MUL, ST_OUT
  } tpi_state_e;

  localparam int unsigned DivW = 49;

  // Point pipeline control travelling with each point
  typedef struct packed {
    logic vld;
    logic last;
    logic half;
  } tpi_ctl_t;
endpackage

### src/tpi_div.sv
// Restoring divider: signed dividend / unsigned divisor, truncated toward zero.
// Depends on tpi_pkg.
module tpi_div
  import tpi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic        [24:0]     divisor_i,
  output logic                   done_o,
  output logic signed [DivW-1:0] quotient_o
);
  logic [DivW-1:0] quo_q, quo_d;
  logic [25:0]     rem_q, rem_d;
  logic [24:0]     dvs_q;
  logic            neg_q;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [25:0]     trial;
  logic [25:0]     shifted;

  always_comb begin
    shifted = {rem_q[24:0], quo_q[DivW-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (busy_q) begin
      if (!trial[25]) begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && !busy_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DivW);
      end else begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[DivW-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DivW-1];
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

### src/tpi_poly.sv
// Three-stage pipeline: point x, then square and linear terms, then f(x) in Q.24.
// Depends on tpi_pkg.
module tpi_poly
  import tpi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpi_ctl_t           ctl_i,
  input  logic signed [33:0] x_i,
  output tpi_ctl_t           ctl_o,
  output logic signed [63:0] f_o
);
  tpi_ctl_t           c1_q, c2_q;
  logic signed [33:0] x1_q;
  logic        [67:0] sq_q;
  logic signed [45:0] lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q  <= '0;
      c2_q  <= '0;
      ctl_o <= '0;
    end else begin
      c1_q  <= ctl_i;
      c2_q  <= c1_q;
      ctl_o <= c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    sq_q  <= 68'(x1_q * x1_q);
    lin_q <= 46'(x1_q) * 46'sd768;
    f_o   <= $signed({sq_q[63:8], 1'b0}) + 64'(lin_q) + 64'sd8388608;
  end
endmodule

### src/tpi_mul.sv
// Pipelined saturating Q.32 product of sum and step, four 32x32 partials.
// Depends on tpi_pkg.
module tpi_mul
  import tpi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] sum_i,
  input  logic signed [DivW-1:0] step_i,
  output logic               done_o,
  output logic signed [63:0] prod_o,
  output logic               ovf_o
);
  logic [63:0] a_q, b_q;
  logic        neg_q, neg2_q;
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  logic [63:0] mid, hi, lo, q, lim;
  logic [2:0]  v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[1:0], start_i};
  end
  assign done_o = v_q[2];

  always_ff @(posedge clk_i) begin
    a_q    <= sum_i[63] ? -sum_i : sum_i;
    b_q    <= 64'(step_i[DivW-1] ? -step_i : step_i);
    neg_q  <= sum_i[63] != step_i[DivW-1];
    p00_q  <= a_q[31:0] * b_q[31:0];
    p01_q  <= a_q[31:0] * b_q[63:32];
    p10_q  <= a_q[63:32] * b_q[31:0];
    p11_q  <= a_q[63:32] * b_q[63:32];
    neg2_q <= neg_q;
  end

  always_comb begin
    mid = 64'(p00_q[63:32]) + 64'(p01_q[31:0]) + 64'(p10_q[31:0]);
    lo  = {mid[31:0], p00_q[31:0]};
    hi  = p11_q + 64'(p01_q[63:32]) + 64'(p10_q[63:32]) + 64'(mid[63:32]);
    q   = {hi[31:0], lo[63:32]};
    lim = neg2_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  end

  always_ff @(posedge clk_i) begin
    if (hi[63:32] != 32'd0 || q > lim) begin
      ovf_o  <= 1'b1;
      prod_o <= neg2_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      ovf_o  <= 1'b0;
      prod_o <= neg2_q ? -$signed(q) : $signed(q);
    end
  end
endmodule

### src/trapezoid_polynomial_integrator_top.sv
// Top level of the trapezoid integrator: sequencer, accumulator, output register.
// Depends on tpi_pkg, tpi_div, tpi_poly, tpi_mul and the assertion macro header.
//
// One request carries a, b (signed Q16.16) and n. The block computes
// h = (b-a)*2^16/n with a 49-step serial divider, then feeds a, b and the
// n-1 interior points, one per cycle, into a three-stage polynomial pipeline
// that returns f(x) in Q.24. The halved end-point sum seeds a saturating
// 64-bit accumulator, the interior points are added to it in order, and a
// three-stage partial-product multiplier forms sum*h/2^32, saturated, with the
// overflow flag. Once the request is taken, the divider runs, then the n+1
// points are issued, the point pipeline drains and the product is formed, and
// the result shows. Requests are handled one at a time; the next one is
// accepted as soon as the result sits in the output register, even while that
// result waits to be taken. The product step holds off until the previous
// result has been taken, so a slow receiver stretches the request.
`include "trapezoid_polynomial_integrator_top_macros.svh"
module trapezoid_polynomial_integrator_top
  import tpi_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic        [20:0] interval_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] area_o,
  output logic               overflow_o
);
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);

  tpi_state_e state_q, state_d;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic [CntW-1:0]    n_q;
  logic [CntW-1:0]    idx_q, idx_d;
  logic signed [DivW+CntW:0] acc_pt_q, acc_pt_d;   // i*h running
  logic signed [DivW-1:0] step_q;
  logic signed [63:0] sum_q, sum_d;
  logic               ovf_q, ovf_d;
  logic [CntW-1:0]    n_sel;
  logic               div_start, div_done;
  logic signed [DivW-1:0] quo;
  tpi_ctl_t           pctl, fctl;
  logic signed [33:0] px;
  logic signed [63:0] fval;
  logic signed [64:0] wide;
  logic               mul_start, mul_done, mul_ovf;
  logic signed [63:0] prod;
  logic               accept;

  // clamp count
  always_comb begin
    if (interval_count_i == 21'd0) n_sel = CntW'(1);
    else if (32'(interval_count_i) > MAX_INTERVALS) n_sel = CntW'(MAX_INTERVALS);
    else n_sel = CntW'(interval_count_i);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept;

  tpi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(DivW'((33'(upper_bound_i) - 33'(lower_bound_i))) <<< 16),
    .divisor_i(25'(n_sel)),
    .done_o(div_done), .quotient_o(quo)
  );

  // sequencer: divider wait, then issue a, b and the interior points in order, then drain and product
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    acc_pt_d = acc_pt_q;
    pctl     = '0;
    px       = 34'(a_q);
    mul_start = 1'b0;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_ENDS;
      ST_ENDS: begin
        pctl     = '{vld: 1'b1, last: 1'b0, half: 1'b1};
        px       = 34'(a_q);
        idx_d    = CntW'(1);
        acc_pt_d = (DivW+CntW+1)'(step_q);
        state_d  = ST_ENDB;
      end
      ST_ENDB: begin
        // a single interval has no interior points
        pctl    = '{vld: 1'b1, last: (n_q == CntW'(1)), half: 1'b1};
        px      = 34'(b_q);
        state_d = (n_q == CntW'(1)) ? ST_DRAIN : ST_LOOP;
      end
      ST_LOOP: begin
        pctl     = '{vld: 1'b1, last: (idx_q == n_q - CntW'(1)), half: 1'b0};
        px       = 34'(a_q) + 34'(acc_pt_q >>> 16);
        idx_d    = idx_q + CntW'(1);
        acc_pt_d = acc_pt_q + (DivW+CntW+1)'(step_q);
        if (idx_q == n_q - CntW'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: if (fctl.vld && fctl.last) begin
        state_d = ST_MUL;
      end
      ST_MUL: if (!out_valid_o) begin
        // wait for the previous result to leave the output register
        mul_start = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: if (mul_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  tpi_poly u_poly (
    .clk_i, .rst_ni, .ctl_i(pctl), .x_i(px), .ctl_o(fctl), .f_o(fval)
  );

  // accumulator: f(a) held, halved end sum seeds the sum, interior added saturating
  logic signed [63:0] ends_q;
  logic               have_a_q;
  logic signed [64:0] ends_sum;
  always_comb begin
    sum_d    = sum_q;
    ovf_d    = ovf_q;
    ends_sum = 65'(ends_q) + 65'(fval);
    wide     = 65'(sum_q) + 65'(fval);
    if (fctl.vld && !fctl.half) begin
      if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
        sum_d = 64'sh7FFF_FFFF_FFFF_FFFF; ovf_d = 1'b1;
      end else if (wide < -65'sh0_8000_0000_0000_0000) begin
        sum_d = 64'sh8000_0000_0000_0000; ovf_d = 1'b1;
      end else sum_d = wide[63:0];
    end else if (fctl.vld && have_a_q) begin
      // f(b) arriving: end sum always fits, floor halving
      sum_d = 64'(ends_sum >>> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
      have_a_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_done) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (fctl.vld && fctl.half) have_a_q <= 1'b1;
      else if (accept) have_a_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= lower_bound_i;
      b_q   <= upper_bound_i;
      n_q   <= n_sel;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      ovf_q <= ovf_d;
    end
    if (div_done) step_q <= quo;
    idx_q    <= idx_d;
    acc_pt_q <= acc_pt_d;
    if (fctl.vld && fctl.half && !have_a_q) ends_q <= fval;
    if (mul_done) begin
      area_o     <= prod;
      overflow_o <= mul_ovf || ovf_q;
    end
  end

  tpi_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .sum_i(sum_q), .step_i(step_q),
    .done_o(mul_done), .prod_o(prod), .ovf_o(mul_ovf)
  );

  `TPI_ASSERT_IMP(a_one_item, in_ready_o, state_q == ST_IDLE)
  `TPI_ASSERT_NXT(a_done_valid, mul_done, out_valid_o)
  `TPI_ASSERT_IMP(a_end_pair, fctl.vld && !fctl.half, have_a_q)
endmodule

### verif/tpi_scoreboard.sv
// Scoreboard for the trapezoid integrator: predicts each area and flag, then compares.
// Depends only on the request and result channels of trapezoid_polynomial_integrator_top.
`timescale 1ns / 1ps
module tpi_scoreboard #(
  parameter int unsigned MAX_INTERVALS = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic        [20:0] interval_count_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [63:0] area_i,
  input  logic               overflow_i,
  output int                 fails_o,
  output int                 pending_o
);
  localparam longint SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SumMin = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] area;
    logic               overflow;
  } area_t;

  area_t area_q[$];

  // f(x) in Q.24 for x in Q16.16
  function automatic longint poly_q24(longint x);
    return 2 * ((x * x) >>> 8) + 768 * x + (longint'(1) <<< 23);
  endfunction

  function automatic longint add_clamp(longint acc, longint add, ref bit ovf);
    if (add > 0 && acc > SumMax - add) begin
      ovf = 1'b1;
      return SumMax;
    end
    if (add < 0 && acc < SumMin - add) begin
      ovf = 1'b1;
      return SumMin;
    end
    return acc + add;
  endfunction

  function automatic area_t integrate(longint a, longint b, longint n_raw);
    longint n, h, sum, x;
    bit ovf;
    bit neg;
    bit [63:0] ma, mb, q, lim;
    bit [127:0] prod;
    area_t r;
    n = n_raw;
    ovf = 1'b0;
    if (n == 0) n = 1;
    if (n > MAX_INTERVALS) n = MAX_INTERVALS;
    h = ((b - a) * 65536) / n;
    sum = (poly_q24(a) + poly_q24(b)) >>> 1;
    for (longint i = 1; i < n; i++) begin
      x = a + ((i * h) >>> 16);
      sum = add_clamp(sum, poly_q24(x), ovf);
    end
    // |sum|*|h|/2^32 truncated, sign applied after, then clamped
    neg = (sum < 0) != (h < 0);
    ma = (sum < 0) ? -sum : sum;
    mb = (h < 0) ? -h : h;
    prod = {64'b0, ma} * {64'b0, mb};
    q = prod[95:32];
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (prod[127:96] != 0 || q > lim) begin
      ovf = 1'b1;
      r.area = neg ? SumMin : SumMax;
    end else begin
      r.area = neg ? -q : q;
    end
    r.overflow = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    area_t exp_r;
    int    errs;
    if (!rst_ni) begin
      area_q.delete();
      fails_o <= 0;
    end else begin
      errs = 0;
      if (in_valid_i && in_ready_i)
        area_q.push_back(integrate(lower_bound_i, upper_bound_i, interval_count_i));
      if (out_valid_i && out_ready_i) begin
        if (area_q.size() == 0) begin
          $error("result with no request outstanding: area %0d", area_i);
          errs = errs + 1;
        end else begin
          exp_r = area_q.pop_front();
          if (exp_r.area !== area_i) begin
            $error("area: expected %0d, got %0d", exp_r.area, area_i);
            errs = errs + 1;
          end
          if (exp_r.overflow !== overflow_i) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, overflow_i);
            errs = errs + 1;
          end
        end
      end
      fails_o <= fails_o + errs;
    end
  end

  assign pending_o = area_q.size();
endmodule

### verif/tb_trapezoid_polynomial_integrator_top.sv
// Testbench top for the trapezoid integrator: clock, reset, request and result traffic.
// Depends on trapezoid_polynomial_integrator_top and tpi_scoreboard.
`timescale 1ns / 1ps
module tb_trapezoid_polynomial_integrator_top;
  localparam int unsigned MaxIntervals = 1048576;
  // one request has a saturated count of MaxIntervals intervals; the rest are short
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned RandomRequests = 100;
  localparam int unsigned DrainCycles = 100;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] lower_bound_i = '0;
  logic signed [31:0] upper_bound_i = '0;
  logic        [20:0] interval_count_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] area_o;
  logic               overflow_o;
  int                 fails;
  int                 pending;
  int unsigned        cycles = 0;
  bit                 sender_idles = 1'b1;
  bit                 receiver_idles = 1'b1;

  always #5 clk_i = ~clk_i;

  trapezoid_polynomial_integrator_top #(.MAX_INTERVALS(MaxIntervals)) dut (.*);

  tpi_scoreboard #(.MAX_INTERVALS(MaxIntervals)) u_scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .lower_bound_i, .upper_bound_i, .interval_count_i,
    .out_valid_i(out_valid_o), .out_ready_i, .area_i(area_o), .overflow_i(overflow_o),
    .fails_o(fails), .pending_o(pending)
  );

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stall before each result while receiver_idles is set, entered at negedge.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Issues one request; called and returns at a falling edge.
  task automatic send_request(logic signed [31:0] a, logic signed [31:0] b,
                              logic [20:0] n);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    lower_bound_i    <= a;
    upper_bound_i    <= b;
    interval_count_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_bound();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2047)) - 1024;
      2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  initial begin
    logic signed [31:0] a;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, reversed bounds, zero and oversized counts, clamped area
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 21'd1);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 21'd1);
    send_request(32'sh0000_0000, 32'sh0001_0000, 21'd0);
    send_request(32'sh0000_0000, 32'sh0001_0000, 21'h1F_FFFF);
    send_request(32'sh0003_0000, 32'sh0003_0000, 21'd7);
    send_request(32'sh0005_0000, -32'sh0002_8000, 21'd10);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 21'd200);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 21'd200);
    send_request(-32'sh0001_0000, 32'sh0001_0000, 21'd2);
    send_request(32'sh0000_0001, 32'sh0000_0002, 21'd3);
    send_request(32'sh8000_0000, 32'sh8000_0000, 21'd1);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 21'd64);

    // hold off until the block has drained
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int k = 0; k < RandomRequests; k++) begin
      // every 25 requests, pick anew at random whether sender and receiver idle
      if (k % 25 == 0) begin
        sender_idles   = $urandom_range(0, 1);
        receiver_idles = $urandom_range(0, 1);
      end
      a = rand_bound();
      send_request(a, $urandom_range(0, 3) == 0 ? a : rand_bound(),
                   $urandom_range(0, 7) == 0 ? 21'($urandom_range(0, 400))
                                             : 21'($urandom_range(0, 40)));
    end
    in_valid_i <= 1'b0;
    receiver_idles = 1'b1;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/tpi_pkg.sv
src/tpi_div.sv
src/tpi_poly.sv
src/tpi_mul.sv
src/trapezoid_polynomial_integrator_top.sv
verif/tpi_scoreboard.sv
verif/tb_trapezoid_polynomial_integrator_top.sv
